[src/tvg_pkg.sv]
// Shared types, constants and the arctangent table of the turtle vector generator.
package tvg_pkg;

   localparam int FRAC_BITS    = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_ITER  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int DEG_UNIT     = 1 << FRAC_BITS;
   localparam int DEG_11       = 11 * DEG_UNIT;
   localparam int DEG_90       = 90 * DEG_UNIT;
   localparam int DEG_180      = 180 * DEG_UNIT;
   localparam int DEG_360      = 360 * DEG_UNIT;
   localparam int SNAP_MAX     = (DEG_UNIT - 1) / 100;
   localparam int ANG_SHIFT    = 16 - FRAC_BITS;
   localparam int CORDIC_K     = 652032874;
   localparam int TRIG_ONE     = 1 << 30;

   typedef enum logic [3:0] {
      OP_FORWARD  = 4'd0,
      OP_TURN     = 4'd1,
      OP_SETHEAD  = 4'd2,
      OP_SETPOS   = 4'd3,
      OP_PENUP    = 4'd4,
      OP_PENDOWN  = 4'd5,
      OP_PENERASE = 4'd6,
      OP_PENREV   = 4'd7,
      OP_HOME     = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      CSR_X_LOW   = 3'd0,
      CSR_X_HIGH  = 3'd1,
      CSR_Y_LOW   = 3'd2,
      CSR_Y_HIGH  = 3'd3,
      CSR_Y_SCALE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PEN_DRAW    = 2'd0,
      PEN_ERASE   = 2'd1,
      PEN_REVERSE = 2'd2,
      PEN_UP      = 2'd3
   } pen_kind_type;

   typedef enum logic [2:0] {
      CMD_FWD,
      CMD_TURN,
      CMD_SETH,
      CMD_SETPOS,
      CMD_PENUP,
      CMD_PENSET,
      CMD_HOME,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [1:0]         pen_kind;
      logic signed [23:0] value;
      logic signed [23:0] value_y;
   } cmd_type;

   typedef struct packed {
      logic               draw;
      logic [1:0]         pen_mode;
      logic signed [23:0] from_x;
      logic signed [23:0] from_y;
      logic signed [23:0] to_x;
      logic signed [23:0] to_y;
      logic [16:0]        heading_now;
      logic               out_of_bounds;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HNORM,
      ST_HRED,
      ST_HSET,
      ST_TRIG,
      ST_FOLD,
      ST_CORDIC,
      ST_SIGN,
      ST_MULS,
      ST_MULC,
      ST_MULE,
      ST_MOVE,
      ST_SCF,
      ST_SCT,
      ST_OUT
   } back_state_type;

   function automatic logic signed [24:0] atan_deg(input logic [4:0] idx);
      logic signed [24:0] r;
      case (idx)
         5'd0:    r = 25'sd2949120;
         5'd1:    r = 25'sd1740967;
         5'd2:    r = 25'sd919879;
         5'd3:    r = 25'sd466945;
         5'd4:    r = 25'sd234379;
         5'd5:    r = 25'sd117304;
         5'd6:    r = 25'sd58666;
         5'd7:    r = 25'sd29335;
         5'd8:    r = 25'sd14668;
         5'd9:    r = 25'sd7334;
         5'd10:   r = 25'sd3667;
         5'd11:   r = 25'sd1833;
         5'd12:   r = 25'sd917;
         5'd13:   r = 25'sd458;
         5'd14:   r = 25'sd229;
         5'd15:   r = 25'sd115;
         5'd16:   r = 25'sd57;
         5'd17:   r = 25'sd29;
         5'd18:   r = 25'sd14;
         5'd19:   r = 25'sd7;
         5'd20:   r = 25'sd4;
         5'd21:   r = 25'sd2;
         5'd22:   r = 25'sd1;
         default: r = 25'sd0;
      endcase
      return r;
   endfunction

endpackage

[src/tvg_front.sv]
// Command front end: accepts request transfers and decodes them into queue entries.
module tvg_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,
   input  logic              q_full,
   output logic              q_push,
   output tvg_pkg::cmd_type  q_cmd
);
   import tvg_pkg::*;

   op_type op;

   assign op         = op_type'(req_tdata[3:0]);
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd.value    = req_tdata[27:4];
      q_cmd.value_y  = req_tdata[51:28];
      q_cmd.pen_kind = PEN_DRAW;
      case (op)
         OP_FORWARD:  q_cmd.kind = CMD_FWD;
         OP_TURN:     q_cmd.kind = CMD_TURN;
         OP_SETHEAD:  q_cmd.kind = CMD_SETH;
         OP_SETPOS:   q_cmd.kind = CMD_SETPOS;
         OP_PENUP:    q_cmd.kind = CMD_PENUP;
         OP_PENDOWN:  q_cmd.kind = CMD_PENSET;
         OP_PENERASE: begin
            q_cmd.kind     = CMD_PENSET;
            q_cmd.pen_kind = PEN_ERASE;
         end
         OP_PENREV: begin
            q_cmd.kind     = CMD_PENSET;
            q_cmd.pen_kind = PEN_REVERSE;
         end
         OP_HOME:     q_cmd.kind = CMD_HOME;
         default:     q_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

[src/tvg_queue.sv]
// Four-entry command queue between the front end and the execution unit.
module tvg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tvg_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output tvg_pkg::cmd_type  pop_cmd,
   output logic              empty
);
   import tvg_pkg::*;

   cmd_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign full    = (count_ff == 3'd4);
   assign empty   = (count_ff == 3'd0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/tvg_back.sv]
// Execution unit: turtle state, heading reduction, CORDIC, moves, y scaling and result register.
module tvg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_data,
   input  logic              q_empty,
   input  tvg_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tvg_pkg::rsp_type  rsp
);
   import tvg_pkg::*;

   localparam logic signed [18:0] H90   = 19'(DEG_90);
   localparam logic signed [18:0] H180  = 19'(DEG_180);
   localparam logic signed [18:0] H360  = 19'(DEG_360);
   localparam logic signed [25:0] T11   = 26'(DEG_11);
   localparam logic signed [25:0] TWRAP = 26'(DEG_360) <<< 7;
   localparam logic signed [31:0] KINIT = 32'(CORDIC_K);
   localparam logic signed [31:0] TONE  = 32'(TRIG_ONE);
   localparam logic signed [55:0] RHALF = 56'sd536870912;
   localparam logic signed [23:0] SNAPL = 24'(SNAP_MAX);

   back_state_type state_ff, state_in;

   logic signed [23:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [15:0]        y_scale_ff;
   logic signed [23:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] head_ff;
   logic               pen_down_ff;
   logic [1:0]         pen_kind_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   cmd_type            cmd_ff;
   logic signed [25:0] t_ff;
   logic [2:0]         k_ff;
   logic signed [18:0] hw_ff;
   logic signed [24:0] ang_ff;
   logic signed [31:0] cx_ff, sy_ff;
   logic               neg_ff;
   logic [4:0]         i_ff;
   logic signed [55:0] prod_ff;
   logic signed [25:0] dx_ff;
   logic signed [26:0] nx_ff, ny_ff;
   logic               draw_ff, oob_ff;
   logic signed [23:0] ox_ff, oy_ff;
   logic signed [23:0] fx_ff, fy_ff, ty_ff;

   logic               load;
   logic               oob_now;
   logic               axis_case;
   logic signed [55:0] rnd;
   logic signed [25:0] red_cmp;
   logic signed [18:0] hfold;
   logic signed [23:0] scale_src;
   logic signed [23:0] scaled;

   function automatic logic signed [23:0] snap(input logic signed [23:0] v);
      logic signed [23:0] a;
      a = v[23] ? -v : v;
      return (a <= SNAPL && !(v == 24'sh800000)) ? 24'sd0 : v;
   endfunction

   function automatic logic signed [23:0] scale_y(input logic signed [23:0] y,
                                                  input logic [15:0] s);
      logic signed [40:0] p;
      logic signed [32:0] r;
      p = 41'(y) * $signed({25'd0, s});
      r = 33'((p + 41'sd128) >>> 8);
      if (r > 33'sd8388607) begin
         return 24'sh7fffff;
      end else if (r < -33'sd8388608) begin
         return 24'sh800000;
      end
      return r[23:0];
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign rnd       = prod_ff + RHALF;
   assign red_cmp   = TWRAP >>> (3'd7 - k_ff);
   assign oob_now   = nx_ff < 27'(x_low_ff) || nx_ff > 27'(x_high_ff) ||
                      ny_ff < 27'(y_low_ff) || ny_ff > 27'(y_high_ff);
   assign axis_case = hw_ff == 19'sd0 || hw_ff == H90 || hw_ff == -H90 || hw_ff == -H180;
   assign hfold     = (hw_ff > H90) ? hw_ff - H180 : ((hw_ff < -H90) ? hw_ff + H180 : hw_ff);
   assign scale_src = (state_ff == ST_SCF) ? (draw_ff ? oy_ff : pos_y_ff) : pos_y_ff;
   assign scaled    = scale_y(scale_src, y_scale_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_cmd.kind)
                  CMD_FWD:    state_in = ST_TRIG;
                  CMD_TURN:   state_in = ST_HNORM;
                  CMD_SETH:   state_in = ST_HNORM;
                  CMD_SETPOS: state_in = ST_MOVE;
                  default:    state_in = ST_SCF;
               endcase
            end
         end
         ST_HNORM:  state_in = ST_HRED;
         ST_HRED:   state_in = (k_ff == 3'd0) ? ST_HSET : ST_HRED;
         ST_HSET:   state_in = ST_SCF;
         ST_TRIG:   state_in = ST_FOLD;
         ST_FOLD:   state_in = axis_case ? ST_MULS : ST_CORDIC;
         ST_CORDIC: state_in = (i_ff == 5'(CORDIC_ITER - 1)) ? ST_SIGN : ST_CORDIC;
         ST_SIGN:   state_in = ST_MULS;
         ST_MULS:   state_in = ST_MULC;
         ST_MULC:   state_in = ST_MULE;
         ST_MULE:   state_in = ST_MOVE;
         ST_MOVE:   state_in = ST_SCF;
         ST_SCF:    state_in = ST_SCT;
         ST_SCT:    state_in = ST_OUT;
         ST_OUT:    state_in = load ? ST_IDLE : ST_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == ST_IDLE) && !q_empty;
      load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_low_ff     <= -24'sd32768;
         x_high_ff    <= 24'sd32767;
         y_low_ff     <= -24'sd32768;
         y_high_ff    <= 24'sd32767;
         y_scale_ff   <= 16'd256;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         pen_down_ff  <= 1'b1;
         pen_kind_ff  <= PEN_DRAW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_X_LOW:   x_low_ff   <= csr_data;
               CSR_X_HIGH:  x_high_ff  <= csr_data;
               CSR_Y_LOW:   y_low_ff   <= csr_data;
               CSR_Y_HIGH:  y_high_ff  <= csr_data;
               CSR_Y_SCALE: y_scale_ff <= csr_data[15:0];
               default:     ;
            endcase
         end
         if (q_pop) begin
            case (q_cmd.kind)
               CMD_PENUP:  pen_down_ff <= 1'b0;
               CMD_PENSET: begin
                  pen_down_ff <= 1'b1;
                  pen_kind_ff <= q_cmd.pen_kind;
               end
               CMD_HOME: begin
                  pos_x_ff <= '0;
                  pos_y_ff <= '0;
                  head_ff  <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_HSET) begin
            head_ff <= 18'(t_ff - T11);
         end
         if (state_ff == ST_MOVE && !oob_now) begin
            pos_x_ff <= snap(nx_ff[23:0]);
            pos_y_ff <= snap(ny_ff[23:0]);
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff  <= q_cmd;
            draw_ff <= 1'b0;
            oob_ff  <= 1'b0;
            nx_ff   <= 27'(q_cmd.value);
            ny_ff   <= 27'(q_cmd.value_y);
            if (q_cmd.kind == CMD_TURN) begin
               t_ff <= 26'(head_ff) + 26'(q_cmd.value) + T11;
            end else begin
               t_ff <= 26'(q_cmd.value) + T11;
            end
         end
         ST_HNORM: begin
            k_ff <= 3'd7;
            if (t_ff < 26'sd0) begin
               t_ff <= t_ff + TWRAP;
            end
         end
         ST_HRED: begin
            k_ff <= k_ff - 3'd1;
            if (t_ff >= red_cmp) begin
               t_ff <= t_ff - red_cmp;
            end
         end
         ST_TRIG: begin
            hw_ff <= (19'(head_ff) >= H180) ? 19'(head_ff) - H360 : 19'(head_ff);
         end
         ST_FOLD: begin
            neg_ff <= 1'b0;
            i_ff   <= '0;
            cx_ff  <= KINIT;
            sy_ff  <= '0;
            ang_ff <= 25'(hfold) <<< ANG_SHIFT;
            if (hw_ff == 19'sd0) begin
               cx_ff <= TONE;
            end else if (hw_ff == H90) begin
               cx_ff <= '0;
               sy_ff <= TONE;
            end else if (hw_ff == -H90) begin
               cx_ff <= '0;
               sy_ff <= -TONE;
            end else if (hw_ff == -H180) begin
               cx_ff <= -TONE;
            end else begin
               neg_ff <= (hw_ff > H90) || (hw_ff < -H90);
            end
         end
         ST_CORDIC: begin
            i_ff <= i_ff + 5'd1;
            if (ang_ff >= 25'sd0) begin
               cx_ff  <= cx_ff - (sy_ff >>> i_ff);
               sy_ff  <= sy_ff + (cx_ff >>> i_ff);
               ang_ff <= ang_ff - atan_deg(i_ff);
            end else begin
               cx_ff  <= cx_ff + (sy_ff >>> i_ff);
               sy_ff  <= sy_ff - (cx_ff >>> i_ff);
               ang_ff <= ang_ff + atan_deg(i_ff);
            end
         end
         ST_SIGN: begin
            if (neg_ff) begin
               cx_ff <= -cx_ff;
               sy_ff <= -sy_ff;
            end
         end
         ST_MULS: prod_ff <= 56'(cmd_ff.value) * 56'(sy_ff);
         ST_MULC: begin
            dx_ff   <= rnd[55:30];
            prod_ff <= 56'(cmd_ff.value) * 56'(cx_ff);
         end
         ST_MULE: begin
            nx_ff <= 27'(pos_x_ff) + 27'(dx_ff);
            ny_ff <= 27'(pos_y_ff) + 27'($signed(rnd[55:30]));
         end
         ST_MOVE: begin
            oob_ff  <= oob_now;
            draw_ff <= !oob_now && pen_down_ff;
            ox_ff   <= pos_x_ff;
            oy_ff   <= pos_y_ff;
         end
         ST_SCF: begin
            fx_ff <= draw_ff ? ox_ff : pos_x_ff;
            fy_ff <= scaled;
         end
         ST_SCT: ty_ff <= scaled;
         ST_OUT: begin
            if (load) begin
               rsp_ff.draw          <= draw_ff;
               rsp_ff.pen_mode      <= pen_down_ff ? pen_kind_ff : PEN_UP;
               rsp_ff.from_x        <= fx_ff;
               rsp_ff.from_y        <= fy_ff;
               rsp_ff.to_x          <= pos_x_ff;
               rsp_ff.to_y          <= ty_ff;
               rsp_ff.heading_now   <= head_ff[17] ? 17'(19'(head_ff) + H360)
                                                   : 17'(head_ff);
               rsp_ff.out_of_bounds <= oob_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

[src/turtle_vector_generator.sv]
// Top level of the turtle vector generator: front end, command queue and execution unit.
//
// Usage: each req transfer carries one turtle command (operation, value, value_y).
// Exactly one rsp transfer follows per command, in order, with the pen mode, the
// heading, the segment end points (y scaled by y_scale and saturated) and flags.
// The csr channel writes the bounds and y_scale registers; it is always ready. It
// must be written only while no command is in flight; the block does not enforce this.
// Steps from request to response: forward folds the heading, runs the CORDIC at one
// iteration a cycle and does two sequential multiplies (the CORDIC is skipped at a
// heading of 0, 90, -90 or 180 degrees); turn and set heading do a modular heading
// reduction, one bit a cycle; forward and set position then do the move; every
// command ends with y scaling and the result register. The execution unit works on
// one command at a time and pops the next only after the result has been loaded.
// A four-entry queue lets requests keep arriving while a command executes, and
// the response register lets the next command start while a result waits.
// Reset: position and heading clear, pen goes down in draw mode, bounds return
// to -128.0 .. 127.996, y_scale to 1.0, queue and response register empty.
// When rsp_tready is low a waiting result holds; the next command then pauses at its result.
module turtle_vector_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[3:0], value[27:4], value_y[51:28], zero[55:52]
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // draw[0], pen_mode[2:1], from_x[26:3], from_y[50:27], to_x[74:51],
   // to_y[98:75], heading_now[115:99], out_of_bounds[116], zero[119:117]
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data
);
   import tvg_pkg::*;

   logic    q_full, q_push, q_pop, q_empty;
   cmd_type push_cmd, pop_cmd;
   rsp_type rsp;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, rsp.out_of_bounds, rsp.heading_now, rsp.to_y, rsp.to_x,
                       rsp.from_y, rsp.from_x, rsp.pen_mode, rsp.draw};

   tvg_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tvg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   tvg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_empty   (q_empty),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

endmodule
